FILE: rtl/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  localparam int IDX_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_BITS = 5;
  localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [VALUE_BITS-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic capture;
    logic exec;
  } lkvc_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/lkvc_if.sv
`default_nettype none

interface lkvc_req_if import lkvc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [KEY_BITS-1:0]   lookup_key;
  logic signed [VALUE_BITS-1:0] store_value;

  modport source (output valid, output opcode, output lookup_key, output store_value,
                  input ready);
  modport sink   (input valid, input opcode, input lookup_key, input store_value,
                  output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [VALUE_BITS-1:0] read_value;
  logic                         evicted;

  modport source (output valid, output hit, output read_value, output evicted,
                  input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/lkvc_ctrl.sv
`default_nettype none

module lkvc_ctrl import lkvc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output lkvc_cmd_t cmd
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_UPDATE = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd.capture    = 1'b0;
    cmd.exec       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // hold until the result register can take the beat
        if (out_free) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_exec_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!out_valid || out_ready))
    else $error("update ran while result register was occupied");

  a_capture_then_exec_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !in_ready)
    else $error("new beat accepted before the previous item finished");

endmodule

`default_nettype wire

FILE: rtl/lkvc_dp.sv
`default_nettype none

module lkvc_dp import lkvc_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lkvc_cmd_t                    cmd,
  input  wire logic                         cfg_wr_en,
  input  wire logic [CAP_BITS-1:0]          cfg_wr_data,
  input  wire logic                         opcode,
  input  wire logic signed [KEY_BITS-1:0]   lookup_key,
  input  wire logic signed [VALUE_BITS-1:0] store_value,
  output logic                              hit,
  output logic signed [VALUE_BITS-1:0]      read_value,
  output logic                              evicted
);

  logic [KEY_BITS-1:0]   key_r  [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] val_r  [MAX_ENTRIES];
  logic [IDX_BITS-1:0]   rank_r [MAX_ENTRIES];
  logic [IDX_BITS-1:0]   rank_next [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;
  logic [MAX_ENTRIES-1:0] valid_next;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic [CAP_BITS-1:0]   cap;

  logic                  op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  hit_q;
  logic [IDX_BITS-1:0]   hit_idx_q;

  logic [MAX_ENTRIES-1:0] match;
  logic                   any_match;
  logic [IDX_BITS-1:0]    match_idx;

  logic [IDX_BITS-1:0]    hit_rank;
  logic [IDX_BITS-1:0]    lru_rank;
  logic [CMP_BITS-1:0]    eff_cap;
  logic                   full;
  logic                   do_evict;
  logic                   do_insert;
  logic [MAX_ENTRIES-1:0] lru_vec;
  logic [MAX_ENTRIES-1:0] valid_kept;
  logic [IDX_BITS-1:0]    slot;
  logic [VALUE_BITS-1:0]  rd_value;

  // Lookup against the incoming key in the accept cycle.
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid[i] && (key_r[i] == lookup_key);
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) match_idx = IDX_BITS'(i);
    end
    any_match = |match;
  end

  // Live ranks are always 0..count-1, so the least recent entry holds count-1.
  always_comb begin
    hit_rank = rank_r[hit_idx_q];
    lru_rank = IDX_BITS'(count - CNT_BITS'(1));
    if (cap == '0) begin
      eff_cap = CMP_BITS'(1);
    end else if (CMP_BITS'(cap) > CMP_BITS'(MAX_ENTRIES)) begin
      eff_cap = CMP_BITS'(MAX_ENTRIES);
    end else begin
      eff_cap = CMP_BITS'(cap);
    end
    full      = CMP_BITS'(count) >= eff_cap;
    do_insert = !hit_q && (op_q == OP_PUT);
    do_evict  = do_insert && full;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      lru_vec[i] = valid[i] && (rank_r[i] == lru_rank);
    end
    valid_kept = valid & ~(do_evict ? lru_vec : '0);
    slot = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_kept[i]) slot = IDX_BITS'(i);
    end
  end

  always_comb begin
    valid_next = valid;
    count_next = count;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_next[i] = rank_r[i];
    end
    if (hit_q) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid[i] && (IDX_BITS'(i) != hit_idx_q) && (rank_r[i] < hit_rank)) begin
          rank_next[i] = rank_r[i] + IDX_BITS'(1);
        end
      end
      rank_next[hit_idx_q] = '0;
    end else if (do_insert) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_kept[i]) rank_next[i] = rank_r[i] + IDX_BITS'(1);
      end
      rank_next[slot]  = '0;
      valid_next       = valid_kept;
      valid_next[slot] = 1'b1;
      count_next       = do_evict ? count : count + CNT_BITS'(1);
    end
  end

  always_comb begin
    if (op_q == OP_PUT) begin
      rd_value = '0;
    end else if (hit_q) begin
      rd_value = val_r[hit_idx_q];
    end else begin
      rd_value = MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      cap   <= CAP_RESET;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) cap <= cfg_wr_data;
      if (cmd.exec) begin
        valid <= valid_next;
        count <= count_next;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          rank_r[i] <= rank_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= opcode;
      key_q     <= lookup_key;
      val_q     <= store_value;
      hit_q     <= any_match;
      hit_idx_q <= match_idx;
    end
    if (cmd.exec) begin
      if (hit_q && (op_q == OP_PUT)) val_r[hit_idx_q] <= val_q;
      if (do_insert) begin
        key_r[slot] <= key_q;
        val_r[slot] <= val_q;
      end
      hit        <= hit_q;
      evicted    <= do_evict;
      read_value <= rd_value;
    end
  end

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    CNT_BITS'($countones(valid)) == count)
    else $error("entry count disagrees with valid bits");

  a_hit_never_evicts: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && hit_q) |=> !evicted)
    else $error("eviction reported on a hit");

  a_get_miss_value: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (op_q == OP_GET) && !hit_q) |=> (read_value == MISS_VALUE))
    else $error("get miss did not return all ones");

  a_evict_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && do_evict) |=> $stable(count))
    else $error("count changed across an evicting insert");

endmodule

`default_nettype wire

FILE: rtl/lru_key_value_cache_top.sv
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement,
// up to 16 entries of 32-bit keys and values. Each request beat is a get
// (opcode 0) or a put (opcode 1) and yields exactly one response beat: hit,
// the value read (all ones on a get miss, zero on any put) and an eviction
// flag. The accept cycle compares the key against every entry in parallel;
// the update state then applies the recency and replacement update and
// loads the response register; the next request is accepted the cycle
// after that, even while the previous response still waits. The update
// stalls only while an untaken response occupies the output register. The
// user must write capacity_in_use (cfg_wr_data, reset 16) only while the
// block is idle; it does not enforce this. Zero acts as one and values
// above 16 act as 16. The store is empty after reset with no clearing pass.
module lru_key_value_cache_top import lkvc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [CAP_BITS-1:0] cfg_wr_data,
  lkvc_req_if.sink                 req,
  lkvc_rsp_if.source               rsp
);

  lkvc_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  lkvc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .opcode      (req.opcode),
    .lookup_key  (req.lookup_key),
    .store_value (req.store_value),
    .hit         (rsp.hit),
    .read_value  (rsp.read_value),
    .evicted     (rsp.evicted)
  );

endmodule

`default_nettype wire
